// ----- sv/pmid_pkg.sv -----
// Shared widths and defaults for the periodic minimum-image distance unit.
package pmid_pkg;

	localparam int IN_W         = 16;
	localparam int CFG_W        = 9;
	localparam int OUT_W        = 20;
	localparam int NCOORD       = 6;
	localparam int NIMAGE       = 27;
	localparam int MAX_SIDE_DEF = 256;
	localparam int BOX_SIDE_RST = 256;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

endpackage

// ----- sv/pmid_wrap.sv -----
// Pipelined reduction of all six coordinates into the range 0 to side-1.
module pmid_wrap import pmid_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [IN_W-1:0]                coord [NCOORD],
	input  logic [$clog2(MAX_SIDE+1)-1:0]         side,
	output logic                                  out_valid,
	output logic [$clog2(MAX_SIDE)-1:0]           red [NCOORD]
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int RW = $clog2(MAX_SIDE);

	// four remainder steps, most significant bit first
	function automatic logic [SW-1:0] rem_step(input logic [SW-1:0] r,
			input logic [3:0] bits, input logic [SW-1:0] sd);
		logic [SW:0]   t;
		logic [SW-1:0] rv;
		rv = r;
		for (int b = 3; b >= 0; b--) begin
			t = {rv, bits[b]};
			if (t >= {1'b0, sd})
				t = t - {1'b0, sd};
			rv = t[SW-1:0];
		end
		return rv;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic            neg_s1 [NCOORD];
	logic            neg_s2 [NCOORD];
	logic            neg_s3 [NCOORD];
	logic            neg_s4 [NCOORD];
	logic            neg_s5 [NCOORD];
	logic [IN_W-1:0] mag_s1 [NCOORD];
	logic [IN_W-1:0] mag_s2 [NCOORD];
	logic [IN_W-1:0] mag_s3 [NCOORD];
	logic [IN_W-1:0] mag_s4 [NCOORD];
	logic [SW-1:0]   rem_s2 [NCOORD];
	logic [SW-1:0]   rem_s3 [NCOORD];
	logic [SW-1:0]   rem_s4 [NCOORD];
	logic [SW-1:0]   rem_s5 [NCOORD];
	logic [RW-1:0]   red_s6 [NCOORD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCOORD; c++) begin
			// split into sign and magnitude; the most negative value maps to 2^15
			neg_s1[c] <= coord[c][IN_W-1];
			mag_s1[c] <= coord[c][IN_W-1] ? (~coord[c] + 1'b1) : coord[c];

			neg_s2[c] <= neg_s1[c];
			mag_s2[c] <= mag_s1[c];
			rem_s2[c] <= rem_step('0, mag_s1[c][15:12], side);

			neg_s3[c] <= neg_s2[c];
			mag_s3[c] <= mag_s2[c];
			rem_s3[c] <= rem_step(rem_s2[c], mag_s2[c][11:8], side);

			neg_s4[c] <= neg_s3[c];
			mag_s4[c] <= mag_s3[c];
			rem_s4[c] <= rem_step(rem_s3[c], mag_s3[c][7:4], side);

			neg_s5[c] <= neg_s4[c];
			rem_s5[c] <= rem_step(rem_s4[c], mag_s4[c][3:0], side);

			// fold a negative remainder back into range
			if (neg_s5[c] && (rem_s5[c] != '0))
				red_s6[c] <= RW'(side - rem_s5[c]);
			else
				red_s6[c] <= RW'(rem_s5[c]);
		end
	end

	assign out_valid = v_s6;
	assign red       = red_s6;

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> ({1'b0, red_s6[0]} < side) && ({1'b0, red_s6[1]} < side) &&
			({1'b0, red_s6[2]} < side) && ({1'b0, red_s6[3]} < side) &&
			({1'b0, red_s6[4]} < side) && ({1'b0, red_s6[5]} < side))
		else $error("reduced coordinate not below side");

endmodule

// ----- sv/pmid_image.sv -----
// Image offsets, squared axis distances and the 27 image sums.
module pmid_image import pmid_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [$clog2(MAX_SIDE)-1:0]           red [NCOORD],
	input  logic [$clog2(MAX_SIDE+1)-1:0]         side,
	output logic                                  out_valid,
	output logic [2*($clog2(MAX_SIDE+1)+4)+1:0]   img_sum [NIMAGE]
);

	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int DW   = SW + 4;
	localparam int QW   = 2 * DW;
	localparam int SUMW = QW + 2;

	logic v_s7, v_s8, v_s9;

	logic signed [DW-1:0] at, au, av, bt, bu, bv;
	logic signed [DW-1:0] dx0_s7, dy0_s7, dz0_s7;
	logic signed [DW-1:0] mul [4];
	logic signed [DW-1:0] dxv [7];
	logic signed [DW-1:0] dyv [5];
	logic signed [DW-1:0] dzv [3];
	logic signed [QW-1:0] px [7];
	logic signed [QW-1:0] py [5];
	logic signed [QW-1:0] pz [3];
	logic [QW-1:0]        sqx_s8 [7];
	logic [QW-1:0]        sqy_s8 [5];
	logic [QW-1:0]        sqz_s8 [3];
	logic [SUMW-1:0]      sum_s9 [NIMAGE];

	assign at = $signed(DW'(red[0]));
	assign au = $signed(DW'(red[1]));
	assign av = $signed(DW'(red[2]));
	assign bt = $signed(DW'(red[3]));
	assign bu = $signed(DW'(red[4]));
	assign bv = $signed(DW'(red[5]));

	assign mul[0] = '0;
	assign mul[1] = $signed(DW'(side));
	assign mul[2] = mul[1] <<< 1;
	assign mul[3] = mul[1] + mul[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s7 <= in_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// unshifted x, y, z differences
	always_ff @(posedge clk) begin
		dx0_s7 <= (at + au - av) - (bt + bu - bv);
		dy0_s7 <= (at - au) - (bt - bu);
		dz0_s7 <= av - bv;
	end

	// x shifts by (i+j-k)*side, y by (i-j)*side, z by k*side
	for (genvar g = 0; g < 7; g++) begin : g_x
		localparam int N = g - 3;
		assign dxv[g] = (N < 0) ? dx0_s7 - mul[(N < 0) ? -N : 0]
			: dx0_s7 + mul[(N < 0) ? 0 : N];
		assign px[g] = dxv[g] * dxv[g];
		always_ff @(posedge clk) sqx_s8[g] <= unsigned'(px[g]);
	end

	for (genvar g = 0; g < 5; g++) begin : g_y
		localparam int N = g - 2;
		assign dyv[g] = (N < 0) ? dy0_s7 - mul[(N < 0) ? -N : 0]
			: dy0_s7 + mul[(N < 0) ? 0 : N];
		assign py[g] = dyv[g] * dyv[g];
		always_ff @(posedge clk) sqy_s8[g] <= unsigned'(py[g]);
	end

	for (genvar g = 0; g < 3; g++) begin : g_z
		localparam int N = g - 1;
		assign dzv[g] = (N < 0) ? dz0_s7 - mul[(N < 0) ? -N : 0]
			: dz0_s7 + mul[(N < 0) ? 0 : N];
		assign pz[g] = dzv[g] * dzv[g];
		always_ff @(posedge clk) sqz_s8[g] <= unsigned'(pz[g]);
	end

	for (genvar i = 0; i < 3; i++) begin : g_i
		for (genvar j = 0; j < 3; j++) begin : g_j
			for (genvar k = 0; k < 3; k++) begin : g_k
				always_ff @(posedge clk)
					sum_s9[i*9 + j*3 + k] <= SUMW'(sqx_s8[i + j - k + 2])
						+ SUMW'(sqy_s8[i - j + 2]) + SUMW'(sqz_s8[k]);
			end
		end
	end

	assign out_valid = v_s9;
	assign img_sum   = sum_s9;

	a_dz_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (dz0_s7 < mul[1]) && (dz0_s7 > -mul[1]))
		else $error("z difference outside one period");

endmodule

// ----- sv/pmid_minsel.sv -----
// Registered three-way minimum tree over the image sums, with output saturation.
module pmid_minsel import pmid_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [2*($clog2(MAX_SIDE+1)+4)+1:0]   img_sum [NIMAGE],
	output logic                                  out_valid,
	output logic [OUT_W-1:0]                      result
);

	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int SUMW = 2 * (SW + 4) + 2;

	function automatic logic [SUMW-1:0] min3(input logic [SUMW-1:0] a,
			input logic [SUMW-1:0] b, input logic [SUMW-1:0] c);
		logic [SUMW-1:0] m;
		m = (b < a) ? b : a;
		return (c < m) ? c : m;
	endfunction

	logic            v_s10, v_s11, v_s12;
	logic [SUMW-1:0] grp_s10 [9];
	logic [SUMW-1:0] grp_s11 [3];
	logic [SUMW-1:0] low;
	logic [OUT_W-1:0] res_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s10 <= in_valid;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	assign low = min3(grp_s11[0], grp_s11[1], grp_s11[2]);

	always_ff @(posedge clk) begin
		for (int g = 0; g < 9; g++)
			grp_s10[g] <= min3(img_sum[3*g], img_sum[3*g + 1], img_sum[3*g + 2]);
		for (int g = 0; g < 3; g++)
			grp_s11[g] <= min3(grp_s10[3*g], grp_s10[3*g + 1], grp_s10[3*g + 2]);
		// clip to the output range
		if (low > OUT_MAX)
			res_s12 <= OUT_MAX;
		else
			res_s12 <= OUT_W'(low);
	end

	assign out_valid = v_s12;
	assign result    = res_s12;

	a_min_le_centre: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> grp_s10[4] <= $past(img_sum[13]))
		else $error("group minimum above the unshifted image");

	a_min_le_group: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 |-> (grp_s11[0] <= $past(grp_s10[0])) && (grp_s11[1] <= $past(grp_s10[3]))
			&& (grp_s11[2] <= $past(grp_s10[6])))
		else $error("second tree level above its inputs");

endmodule

// ----- sv/periodic_min_image_distance_unit.sv -----
// Top level of the periodic minimum-image distance unit.
//
// Command channel: an item (first_t/u/v, second_t/u/v) is taken at a rising
// edge with start high and busy low. busy stays low, so a new pair can be
// issued on every clock.
// Result: done is high for one cycle with twice_distance_sq valid; the
// result leaves at the edge that closes that cycle and cannot be held off.
// Throughput is one item per cycle through the twelve-stage pipeline: six
// stages of sign split, four-bit restoring remainder steps and the negative
// fold, three of image offsets, squares and sums, and three of a three-way
// minimum tree with output clipping.
// Configuration: cfg_valid/cfg_ready write box_side through cfg_data; cfg_ready
// is always high. Write only when no item is in flight. Zero acts as one and
// values above MAX_SIDE act as MAX_SIDE.
// Reset: arst_n clears all valid bits at once and loads a side of 256
// (clipped to MAX_SIDE); no clearing pass is needed.
module periodic_min_image_distance_unit import pmid_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  first_t,
	input  logic signed [IN_W-1:0]  first_u,
	input  logic signed [IN_W-1:0]  first_v,
	input  logic signed [IN_W-1:0]  second_t,
	input  logic signed [IN_W-1:0]  second_u,
	input  logic signed [IN_W-1:0]  second_v,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    done,
	output logic [OUT_W-1:0]        twice_distance_sq
);

	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int RW       = $clog2(MAX_SIDE);
	localparam int SUMW     = 2 * (SW + 4) + 2;
	localparam int SIDE_RST = (BOX_SIDE_RST > MAX_SIDE) ? MAX_SIDE : BOX_SIDE_RST;

	logic [SW-1:0]          side_q;
	logic [SW-1:0]          side_d;
	logic                   accept;
	logic signed [IN_W-1:0] coord [NCOORD];
	logic                   wrap_valid, img_valid;
	logic [RW-1:0]          red [NCOORD];
	logic [SUMW-1:0]        img_sum [NIMAGE];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// clamp the written side into 1..MAX_SIDE
	always_comb begin
		if (cfg_data == '0)
			side_d = SW'(1);
		else if (cfg_data > MAX_SIDE)
			side_d = SW'(MAX_SIDE);
		else
			side_d = SW'(cfg_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_q <= SW'(SIDE_RST);
		else if (cfg_valid && cfg_ready)
			side_q <= side_d;
	end

	assign coord[0] = first_t;
	assign coord[1] = first_u;
	assign coord[2] = first_v;
	assign coord[3] = second_t;
	assign coord[4] = second_u;
	assign coord[5] = second_v;

	pmid_wrap #(.MAX_SIDE(MAX_SIDE)) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.coord     (coord),
		.side      (side_q),
		.out_valid (wrap_valid),
		.red       (red)
	);

	pmid_image #(.MAX_SIDE(MAX_SIDE)) u_image (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wrap_valid),
		.red       (red),
		.side      (side_q),
		.out_valid (img_valid),
		.img_sum   (img_sum)
	);

	pmid_minsel #(.MAX_SIDE(MAX_SIDE)) u_minsel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (img_valid),
		.img_sum   (img_sum),
		.out_valid (done),
		.result    (twice_distance_sq)
	);

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##12 done)
		else $error("accepted item produced no result");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 12))
		else $error("result without an accepted item");

	a_side_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(side_q != '0) && (side_q <= MAX_SIDE))
		else $error("side register outside its range");

endmodule

// ----- verif/min_image_checker.sv -----
// Checker for the periodic minimum-image distance unit: predicts each result and compares it.
`timescale 1ns / 100ps

module min_image_checker import pmid_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic signed [IN_W-1:0] first_t,
	input  logic signed [IN_W-1:0] first_u,
	input  logic signed [IN_W-1:0] first_v,
	input  logic signed [IN_W-1:0] second_t,
	input  logic signed [IN_W-1:0] second_u,
	input  logic signed [IN_W-1:0] second_v,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   done,
	input  logic [OUT_W-1:0]       twice_distance_sq,
	output int                     pending,
	output int                     fail_count
);

	logic [CFG_W-1:0] box_side_q;
	logic [OUT_W-1:0] expected_dist_q [$];

	function automatic logic [OUT_W-1:0] min_image_dist2(
		input logic [CFG_W-1:0]       side_reg,
		input logic signed [IN_W-1:0] ft, fu, fv, st, su, sv
	);
		logic signed [IN_W-1:0] raw [6];
		longint span, best, sq, dx, dy, dz, t, u, v, bx, by, bz;
		longint a [3];
		longint b [3];
		int c, i, j, k;
		raw = '{ft, fu, fv, st, su, sv};
		span = side_reg;
		if (span < 1) span = 1;
		if (span > MAX_SIDE) span = MAX_SIDE;
		// C-style remainder, then fold negatives into 0..span-1
		for (c = 0; c < 3; c++) begin
			a[c] = longint'(raw[c]) % span;
			if (a[c] < 0) a[c] += span;
			b[c] = longint'(raw[c+3]) % span;
			if (b[c] < 0) b[c] += span;
		end
		bx = b[0] + b[1] - b[2];
		by = b[0] - b[1];
		bz = b[2];
		best = 64'sh7FFF_FFFF_FFFF_FFFF;
		for (i = -1; i <= 1; i++) begin
			for (j = -1; j <= 1; j++) begin
				for (k = -1; k <= 1; k++) begin
					t = a[0] + i * span;
					u = a[1] + j * span;
					v = a[2] + k * span;
					dx = (t + u - v) - bx;
					dy = (t - u) - by;
					dz = v - bz;
					sq = dx * dx + dy * dy + dz * dz;
					if (sq < best) best = sq;
				end
			end
		end
		if (best > longint'(OUT_MAX)) return OUT_MAX;
		return best[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_side_q <= CFG_W'(BOX_SIDE_RST);
			expected_dist_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin : watch
			logic [OUT_W-1:0] want;
			if (done) begin
				if (expected_dist_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %0d with nothing outstanding",
							twice_distance_sq);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_dist_q.pop_front();
					if (twice_distance_sq !== want) begin
						if (fail_count < 10)
							$display("twice_distance_sq mismatch: expected %0d, got %0d",
								want, twice_distance_sq);
						fail_count <= fail_count + 1;
					end
				end
			end
			// predict with the side in force before any write at this edge
			if (start && !busy)
				expected_dist_q.push_back(min_image_dist2(box_side_q, first_t, first_u,
					first_v, second_t, second_u, second_v));
			if (cfg_valid && cfg_ready)
				box_side_q <= cfg_data;
			pending <= expected_dist_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: drives pairs and side writes into the distance unit and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
	import pmid_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 183;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [IN_W-1:0] first_t, first_u, first_v;
	logic signed [IN_W-1:0] second_t, second_u, second_v;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;
	logic                   done;
	logic [OUT_W-1:0]       twice_distance_sq;
	int                     pending;
	int                     fail_count;
	int                     quiet_cycles = 0;
	int                     steady_left = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	periodic_min_image_distance_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.first_t          (first_t),
		.first_u          (first_u),
		.first_v          (first_v),
		.second_t         (second_t),
		.second_u         (second_u),
		.second_v         (second_v),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.done             (done),
		.twice_distance_sq(twice_distance_sq)
	);

	min_image_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.first_t          (first_t),
		.first_u          (first_u),
		.first_v          (first_v),
		.second_t         (second_t),
		.second_u         (second_u),
		.second_v         (second_v),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.done             (done),
		.twice_distance_sq(twice_distance_sq),
		.pending          (pending),
		.fail_count       (fail_count)
	);

	// abort if nothing at all is transferred for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int gap_length();
		int r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			steady_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [IN_W-1:0] rand_coord(input int span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return IN_W'($urandom());
		if (r < 6) return IN_W'(int'($urandom_range(0, 2 * span + 1)) - span);
		if (r < 8)
			return IN_W'((int'($urandom_range(0, 200)) - 100) * span
				+ int'($urandom_range(0, 2)) - 1);
		case ($urandom_range(0, 3))
			0:       return IN_W'(-32768);
			1:       return IN_W'(32767);
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	task automatic issue_pair(input logic signed [IN_W-1:0] ft, fu, fv, st, su, sv);
		int gap;
		@(negedge clk);
		start    = 1'b1;
		first_t  = ft;
		first_u  = fu;
		first_v  = fv;
		second_t = st;
		second_u = su;
		second_v = sv;
		do @(posedge clk); while (busy);
		gap = gap_length();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_box_side(input logic [CFG_W-1:0] value);
		drain_pipeline();
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] sides [10];
		int span;
		arst_n    = 1'b0;
		start     = 1'b0;
		first_t   = '0;
		first_u   = '0;
		first_v   = '0;
		second_t  = '0;
		second_u  = '0;
		second_v  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed pairs at the reset side of 256
		issue_pair(0, 0, 0, 0, 0, 0);
		issue_pair(32767, 32767, 32767, 32767, 32767, 32767);
		issue_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		issue_pair(32767, 32767, 32767, -32768, -32768, -32768);
		issue_pair(-32768, 32767, -32768, 32767, -32768, 32767);
		issue_pair(255, 255, 255, 0, 0, 0);
		issue_pair(256, 512, -256, 0, 0, 0);
		issue_pair(-1, -1, -1, 0, 0, 0);
		issue_pair(128, 128, 128, 0, 0, 0);
		issue_pair(0, 128, 0, 128, 0, 0);
		issue_pair(1, 0, 0, 0, 0, 0);
		issue_pair(0, 0, 255, 0, 0, 0);
		issue_pair(21845, -21846, 21845, -21846, 21845, -21846);
		issue_pair(100, -37, 250, -4000, 7, 129);

		// zero acts as one, anything above the limit is clamped
		sides = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd511, 9'd257, 9'd255, 9'd128,
			9'd0, 9'd256};
		sides[8] = CFG_W'($urandom_range(4, 254));
		foreach (sides[p]) begin
			write_box_side(sides[p]);
			span = sides[p];
			if (span < 1) span = 1;
			if (span > MAX_SIDE_DEF) span = MAX_SIDE_DEF;
			repeat (PHASE_ITEMS)
				issue_pair(rand_coord(span), rand_coord(span), rand_coord(span),
					rand_coord(span), rand_coord(span), rand_coord(span));
		end

		drain_pipeline();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/pmid_pkg.sv
sv/pmid_wrap.sv
sv/pmid_image.sv
sv/pmid_minsel.sv
sv/periodic_min_image_distance_unit.sv
verif/min_image_checker.sv
verif/tb_top.sv
